FILE: src/hsv2rgb_pkg.sv
// shared types and constants for the hsv to rgb palette converter pipeline
// no dependencies; imported by every module of the converter

package hsv2rgb_pkg;

  // field widths
  localparam int HUE_W = 15;
  localparam int FRAC_W = 17;
  localparam int REM_W = 12;

  // one sector spans 60 degrees in 1/64 degree units
  localparam int SECTOR_UNITS = 3840;
  localparam int NUM_CUTS = (2 ** HUE_W - 1) / SECTOR_UNITS;
  localparam int SEC_CNT_W = $clog2(NUM_CUTS + 1);

  // channel term scaled by 65536 * 3840, full scale value
  localparam int MAG_W = 28;
  localparam logic [MAG_W-1:0] ONE_V = MAG_W'(65536 * SECTOR_UNITS);
  localparam int PROD_W = FRAC_W + REM_W;
  localparam int DIFF_W = PROD_W + 1;

  // value times term, then times 17 (255 / 15), then shifted down by 2^40
  localparam int WIDE_W = FRAC_W + MAG_W;
  localparam int SCALED_W = WIDE_W + 5;
  localparam int SCALE_SHIFT = 40;
  localparam int CHAN_BITS = 8;
  localparam int TOP_W = SCALED_W - SCALE_SHIFT;
  localparam int OUT_BITS_DEF = 6;

  // hue sectors, named by the colors they run between
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic [REM_W-1:0] rem;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] val;
  } sec_item_t;

  // one channel term: positive flag and magnitude
  typedef struct packed {
    logic pos;
    logic [MAG_W-1:0] mag;
  } term_t;

  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
    logic [FRAC_W-1:0] val;
  } term_item_t;

endpackage

FILE: src/hsv2rgb_sector.sv
// first pipeline stage: splits the hue into a 60 degree sector and a remainder
// depends on hsv2rgb_pkg

module hsv2rgb_sector (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0] sat,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0] val,
  output logic out_valid,
  input  logic out_ready,
  output hsv2rgb_pkg::sec_item_t out_item
);
  import hsv2rgb_pkg::*;

  logic valid_r;
  sec_item_t item_r;
  sec_item_t item_nxt;
  logic [SEC_CNT_W-1:0] sec_full;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] rem_full;

  // stage loads when empty or when its item moves on
  assign in_ready = !valid_r || out_ready;

  // sector count by compare against each 60 degree boundary
  always_comb begin
    sec_full = '0;
    base = '0;
    for (int k = 1; k <= NUM_CUTS; k++) begin
      if (hue >= HUE_W'(k * SECTOR_UNITS)) begin
        sec_full = SEC_CNT_W'(k);
        base = HUE_W'(k * SECTOR_UNITS);
      end
    end
  end

  // remainder and sector code; everything past the fifth sector shares it
  always_comb begin
    rem_full = hue - base;
    item_nxt.rem = rem_full[REM_W-1:0];
    item_nxt.sat = sat;
    item_nxt.val = val;
    if (sec_full >= SEC_CNT_W'(SEC_MAG_RED)) begin
      item_nxt.sector = SEC_MAG_RED;
    end else begin
      item_nxt.sector = sector_t'(sec_full[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item = item_r;

  // remainder always falls inside one sector
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.rem < REM_W'(SECTOR_UNITS))
    else $error("sector remainder out of range");

  // a held item stays put while the next stage is busy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(item_r))
    else $error("sector stage lost an item under stall");

endmodule

FILE: src/hsv2rgb_terms.sv
// stages two and three: forms the p, q and t terms and routes them per sector
// depends on hsv2rgb_pkg

module hsv2rgb_terms (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  hsv2rgb_pkg::sec_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output hsv2rgb_pkg::term_item_t out_item
);
  import hsv2rgb_pkg::*;

  logic a_valid_r;
  logic a_ready;
  sector_t a_sector_r;
  logic [FRAC_W-1:0] a_val_r;
  logic [PROD_W-1:0] a_sp_r;
  logic [PROD_W-1:0] a_sq_r;
  logic [PROD_W-1:0] a_st_r;
  logic [REM_W-1:0] crem;

  logic b_valid_r;
  logic b_ready;
  term_item_t b_item_r;
  term_item_t b_item_nxt;
  term_t v_term;
  term_t p_term;
  term_t q_term;
  term_t t_term;

  function automatic term_t make_term(input logic [PROD_W-1:0] prod);
    logic [DIFF_W-1:0] d;
    term_t t;
    d = DIFF_W'(ONE_V) - DIFF_W'(prod);
    t.pos = !d[DIFF_W-1] && (d != '0);
    t.mag = d[MAG_W-1:0];
    return t;
  endfunction

  // ready chain from the back
  assign b_ready = !b_valid_r || out_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // stage a: saturation products
  assign crem = REM_W'(SECTOR_UNITS) - in_item.rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_sector_r <= in_item.sector;
      a_val_r <= in_item.val;
      a_sp_r <= PROD_W'(in_item.sat) * PROD_W'(SECTOR_UNITS);
      a_sq_r <= PROD_W'(in_item.sat) * PROD_W'(in_item.rem);
      a_st_r <= PROD_W'(in_item.sat) * PROD_W'(crem);
    end
  end

  // stage b: terms and sector routing
  always_comb begin
    v_term.pos = 1'b1;
    v_term.mag = ONE_V;
    p_term = make_term(a_sp_r);
    q_term = make_term(a_sq_r);
    t_term = make_term(a_st_r);
  end

  always_comb begin
    b_item_nxt.val = a_val_r;
    case (a_sector_r)
      SEC_RED_YEL: begin
        b_item_nxt.red = v_term;
        b_item_nxt.green = t_term;
        b_item_nxt.blue = p_term;
      end
      SEC_YEL_GRN: begin
        b_item_nxt.red = q_term;
        b_item_nxt.green = v_term;
        b_item_nxt.blue = p_term;
      end
      SEC_GRN_CYN: begin
        b_item_nxt.red = p_term;
        b_item_nxt.green = v_term;
        b_item_nxt.blue = t_term;
      end
      SEC_CYN_BLU: begin
        b_item_nxt.red = p_term;
        b_item_nxt.green = q_term;
        b_item_nxt.blue = v_term;
      end
      SEC_BLU_MAG: begin
        b_item_nxt.red = t_term;
        b_item_nxt.green = p_term;
        b_item_nxt.blue = v_term;
      end
      default: begin
        b_item_nxt.red = v_term;
        b_item_nxt.green = p_term;
        b_item_nxt.blue = q_term;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_item = b_item_r;

  // a positive term never exceeds full scale
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (!b_item_r.red.pos || b_item_r.red.mag <= ONE_V)
      && (!b_item_r.green.pos || b_item_r.green.mag <= ONE_V)
      && (!b_item_r.blue.pos || b_item_r.blue.mag <= ONE_V))
    else $error("channel term above full scale");

  // one channel always carries the full value term
  a_max_chan: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_item_r.red.pos && b_item_r.red.mag == ONE_V)
      || (b_item_r.green.pos && b_item_r.green.mag == ONE_V)
      || (b_item_r.blue.pos && b_item_r.blue.mag == ONE_V))
    else $error("no channel holds the value term");

  // product stage keeps its item while the routing stage is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_sq_r) && $stable(a_sector_r))
    else $error("product stage lost an item under stall");

endmodule

FILE: src/hsv2rgb_scale.sv
// stages four and five: multiplies value by the routed terms, scales to palette codes
// depends on hsv2rgb_pkg

module hsv2rgb_scale #(
  parameter int OUT_BITS = hsv2rgb_pkg::OUT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  hsv2rgb_pkg::term_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output logic [OUT_BITS-1:0] red,
  output logic [OUT_BITS-1:0] green,
  output logic [OUT_BITS-1:0] blue
);
  import hsv2rgb_pkg::*;

  // largest value code times the full scale term
  localparam logic [WIDE_W-1:0] PROD_MAX = WIDE_W'(2 ** FRAC_W - 1) * WIDE_W'(ONE_V);

  logic m_valid_r;
  logic m_ready;
  logic [WIDE_W-1:0] m_red_r;
  logic [WIDE_W-1:0] m_green_r;
  logic [WIDE_W-1:0] m_blue_r;

  logic o_valid_r;
  logic o_ready;
  logic [OUT_BITS-1:0] o_red_r;
  logic [OUT_BITS-1:0] o_green_r;
  logic [OUT_BITS-1:0] o_blue_r;

  function automatic logic [WIDE_W-1:0] mul_term(input logic [FRAC_W-1:0] v,
                                                 input term_t t);
    logic [WIDE_W-1:0] prod;
    prod = WIDE_W'(v) * WIDE_W'(t.mag);
    return t.pos ? prod : '0;
  endfunction

  // times 17, keep the integer part, clamp to 255, keep the top bits
  function automatic logic [OUT_BITS-1:0] to_code(input logic [WIDE_W-1:0] x);
    logic [SCALED_W-1:0] y;
    logic [TOP_W-1:0] top;
    logic [CHAN_BITS-1:0] chan;
    y = {x, 4'b0000} + SCALED_W'(x);
    top = y[SCALED_W-1:SCALE_SHIFT];
    if (top > TOP_W'(2 ** CHAN_BITS - 1)) begin
      chan = '1;
    end else begin
      chan = top[CHAN_BITS-1:0];
    end
    return chan[CHAN_BITS-1 -: OUT_BITS];
  endfunction

  assign o_ready = !o_valid_r || out_ready;
  assign m_ready = !m_valid_r || o_ready;
  assign in_ready = m_ready;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_ready) begin
      m_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_red_r <= mul_term(in_item.val, in_item.red);
      m_green_r <= mul_term(in_item.val, in_item.green);
      m_blue_r <= mul_term(in_item.val, in_item.blue);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_ready) begin
      o_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && m_valid_r) begin
      o_red_r <= to_code(m_red_r);
      o_green_r <= to_code(m_green_r);
      o_blue_r <= to_code(m_blue_r);
    end
  end

  assign out_valid = o_valid_r;
  assign red = o_red_r;
  assign green = o_green_r;
  assign blue = o_blue_r;

  // value times term never exceeds the largest value at full scale
  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> m_red_r <= PROD_MAX
      && m_green_r <= PROD_MAX
      && m_blue_r <= PROD_MAX)
    else $error("value times term out of range");

  // multiply stage keeps its item while the output is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r && !o_ready |=> m_valid_r && $stable(m_red_r) && $stable(m_blue_r))
    else $error("multiply stage lost an item under stall");

endmodule

FILE: src/hsv_to_rgb666_converter.sv
// top level of the hsv to rgb palette converter: three pipeline sections
// depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_terms, hsv2rgb_scale

// Converts one HSV color per clock (hue in 1/64 degree, saturation and value
// as Q1.16 fractions) into red, green and blue palette codes of OUT_BITS bits
// each (clamp(trunc(c * 255), 0, 255) shifted down to OUT_BITS). The pipeline
// has five register stages: sector split, saturation products, term routing,
// value multiply, output scaling; an item passes through them in that order,
// and out_valid rises once it reaches the output register. One item is taken
// every cycle while the output is not held. A held output fills the pipeline
// stage by stage, then in_stall rises. The arithmetic is exact: results match
// the rational formula bit for bit.

module hsv_to_rgb666_converter #(
  parameter int OUT_BITS = hsv2rgb_pkg::OUT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0] in_saturation,
  input  logic [hsv2rgb_pkg::FRAC_W-1:0] in_brightness,
  output logic out_valid,
  input  logic out_stall,
  output logic [OUT_BITS-1:0] out_red,
  output logic [OUT_BITS-1:0] out_green,
  output logic [OUT_BITS-1:0] out_blue
);
  import hsv2rgb_pkg::*;

  logic sec_in_ready;
  logic sec_valid;
  logic terms_in_ready;
  sec_item_t sec_item;
  logic terms_valid;
  logic scale_in_ready;
  term_item_t terms_item;

  assign in_stall = !sec_in_ready;

  // hue split
  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (sec_in_ready),
    .hue       (in_hue),
    .sat       (in_saturation),
    .val       (in_brightness),
    .out_valid (sec_valid),
    .out_ready (terms_in_ready),
    .out_item  (sec_item)
  );

  // p, q, t terms and routing
  hsv2rgb_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sec_valid),
    .in_ready  (terms_in_ready),
    .in_item   (sec_item),
    .out_valid (terms_valid),
    .out_ready (scale_in_ready),
    .out_item  (terms_item)
  );

  // value multiply and palette scaling
  hsv2rgb_scale #(
    .OUT_BITS (OUT_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (terms_valid),
    .in_ready  (scale_in_ready),
    .in_item   (terms_item),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

endmodule

FILE: verif/tb_hsv_to_rgb666_converter.sv
// testbench for the hsv to rgb palette converter: directed and random colors
// against a built-in predictor; depends on hsv2rgb_pkg and hsv_to_rgb666_converter
`timescale 1ns / 100ps

module tb_hsv_to_rgb666_converter;
  import hsv2rgb_pkg::*;

  localparam int OUT_W = OUT_BITS_DEF;
  localparam longint ONE_Q16 = 65536;
  localparam longint SEC_SPAN = SECTOR_UNITS;
  localparam longint FULL_SCALE = 255;
  localparam longint DENOM = ONE_Q16 * ONE_Q16 * SEC_SPAN;
  localparam int HUE_FULL = 23040;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [HUE_W-1:0] in_hue;
  logic [FRAC_W-1:0] in_saturation;
  logic [FRAC_W-1:0] in_brightness;
  logic out_valid;
  logic out_stall;
  logic [OUT_W-1:0] out_red;
  logic [OUT_W-1:0] out_green;
  logic [OUT_W-1:0] out_blue;

  rgb_t expected_colors[$];
  int error_count = 0;
  int cycle_count = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  hsv_to_rgb666_converter #(
    .OUT_BITS(OUT_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_hue(in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // one channel scaled by DENOM to its palette code
  function automatic logic [OUT_W-1:0] palette_code(longint num);
    longint scaled;
    if (num <= 0) return '0;
    scaled = (num * FULL_SCALE) / DENOM;
    if (scaled > 255) scaled = 255;
    return OUT_W'(scaled >>> (8 - OUT_W));
  endfunction

  // exact rational hsv to rgb, every term kept scaled by 65536 * 65536 * 3840
  function automatic rgb_t hsv_to_palette(logic [HUE_W-1:0] hue,
                                          logic [FRAC_W-1:0] sat,
                                          logic [FRAC_W-1:0] bri);
    longint h, s, v, sec, rem, vn, pn, qn, tn, r, g, b;
    rgb_t color;
    h = hue;
    s = sat;
    v = bri;
    vn = v * ONE_Q16 * SEC_SPAN;
    if (s == 0) begin
      r = vn;
      g = vn;
      b = vn;
    end else begin
      sec = h / SEC_SPAN;
      rem = h % SEC_SPAN;
      pn = v * ((ONE_Q16 - s) * SEC_SPAN);
      qn = v * (ONE_Q16 * SEC_SPAN - s * rem);
      tn = v * (ONE_Q16 * SEC_SPAN - s * (SEC_SPAN - rem));
      // hue of 360 and above lands in the magenta to red routing
      case (sec)
        longint'(SEC_RED_YEL): begin r = vn; g = tn; b = pn; end
        longint'(SEC_YEL_GRN): begin r = qn; g = vn; b = pn; end
        longint'(SEC_GRN_CYN): begin r = pn; g = vn; b = tn; end
        longint'(SEC_CYN_BLU): begin r = pn; g = qn; b = vn; end
        longint'(SEC_BLU_MAG): begin r = tn; g = pn; b = vn; end
        default: begin r = vn; g = pn; b = qn; end
      endcase
    end
    color.red = palette_code(r);
    color.green = palette_code(g);
    color.blue = palette_code(b);
    return color;
  endfunction

  task automatic flag_error(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // send one item, holding it until accepted
  task automatic send_color(int hue, int sat, int bri);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hue <= HUE_W'(hue);
    in_saturation <= FRAC_W'(sat);
    in_brightness <= FRAC_W'(bri);
    do @(posedge clk); while (in_stall);
    expected_colors.push_back(hsv_to_palette(HUE_W'(hue), FRAC_W'(sat), FRAC_W'(bri)));
  endtask

  // hold the sender idle until the pipeline has emptied
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // zero saturation gives grey
  task automatic test_grey();
    send_color(0, 0, 0);
    send_color(12345, 0, 65536);
    send_color(32767, 0, 131071);
    send_color(23040, 0, 33333);
  endtask

  // every sector at full saturation and value, plus sector edges
  task automatic test_sectors();
    send_color(0, 65536, 65536);
    send_color(3840 + 1920, 65536, 65536);
    send_color(7680 + 100, 65536, 65536);
    send_color(11520 + 3000, 65536, 65536);
    send_color(15360 + 3839, 65536, 65536);
    send_color(19200 + 500, 65536, 65536);
    send_color(23039, 65535, 65535);
    send_color(3839, 1, 131071);
  endtask

  // hue of 360 and beyond
  task automatic test_hue_wrap();
    send_color(HUE_FULL, 40000, 50000);
    send_color(26880, 30000, 60000);
    send_color(32767, 65536, 65536);
  endtask

  // saturation above one drives terms negative, value above one clamps
  task automatic test_overrange();
    send_color(5000, 131071, 65536);
    send_color(17000, 100000, 131071);
    send_color(9000, 65536, 131071);
    send_color(1, 1, 1);
    send_color(32767, 131071, 131071);
  endtask

  // mostly in-range colors, some full-width noise, with pacing phases
  task automatic test_random();
    int hue, sat, bri;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) drain_pipeline();
      if ($urandom_range(0, 4) != 0) begin
        hue = $urandom_range(0, HUE_FULL);
        sat = $urandom_range(0, 65536);
        bri = $urandom_range(0, 65536);
        case ($urandom_range(0, 9))
          0: sat = 0;
          1: sat = 65536;
          2: bri = 65536;
          3: hue = SECTOR_UNITS * $urandom_range(0, 6);
          default: ;
        endcase
      end else begin
        hue = $urandom & 32'h7fff;
        sat = $urandom & 32'h1ffff;
        bri = $urandom & 32'h1ffff;
      end
      send_color(hue, sat, bri);
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  // receiver pacing: a random hold before each result
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = recv_calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        flag_error("result with no item pending");
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red)
          flag_error($sformatf("red %0d, expected %0d", out_red, want.red));
        if (out_green !== want.green)
          flag_error($sformatf("green %0d, expected %0d", out_green, want.green));
        if (out_blue !== want.blue)
          flag_error($sformatf("blue %0d, expected %0d", out_blue, want.blue));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_hue = '0;
    in_saturation = '0;
    in_brightness = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_grey();
    test_sectors();
    test_hue_wrap();
    test_overrange();
    drain_pipeline();
    test_random();
    in_valid <= 1'b0;
    drain_pipeline();
    repeat (20) @(posedge clk);
    if (expected_colors.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_colors.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
